// File: sv/prb_rbg_grant_bitmap_core_assert.svh
// Assertion macros for the RBG/PRB grant bitmap core.
// Each property is clocked on the given clock and held off while reset is low.
`ifndef PRB_RBG_GRANT_BITMAP_CORE_ASSERT_SVH
`define PRB_RBG_GRANT_BITMAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PRBG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("prbg assertion failed");
`define PRBG_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("prbg forbidden condition seen");
`else
`define PRBG_ASSERT(label, clk, rst_n, prop)
`define PRBG_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: sv/prbg_pkg.sv
`timescale 1ns / 1ps

package prbg_pkg;

    // Width of the RBG mask fields
    localparam int RBG_W = 19;

    // Operation codes
    localparam logic [1:0] FUNC_INTERVAL = 2'd0;
    localparam logic [1:0] FUNC_WORD     = 2'd1;
    localparam logic [1:0] FUNC_MASK     = 2'd2;
    localparam logic [1:0] FUNC_READ     = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRB_COUNT  = 2'd0;
    localparam logic [1:0] CFG_PRB_START  = 2'd1;
    localparam logic [1:0] CFG_CONFIG_ONE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the input item
        logic step;    // apply the operation for the current RBG index
        logic finish;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;  // latched operation
        logic [4:0] nrbg;  // RBG count of the bandwidth part
    } t_dp_sts;

endpackage

// File: sv/prbg_if.sv
`timescale 1ns / 1ps

// Input item channel
interface prbg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [8:0]  prb_first;
    logic [8:0]  prb_stop;
    logic [2:0]  word_index;
    logic [63:0] prb_word;
    logic [18:0] rbg_mask;

    modport source (
        output valid, func, prb_first, prb_stop, word_index, prb_word, rbg_mask,
        input  ready
    );
    modport sink (
        input  valid, func, prb_first, prb_stop, word_index, prb_word, rbg_mask,
        output ready
    );
endinterface

// Result channel
interface prbg_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] rbg_mask_now;
    logic [63:0] prb_word_out;
    logic [4:0]  rbg_count;
    logic [4:0]  first_rbg_width;
    logic [4:0]  nominal_rbg_width;
    logic        bad_request;

    modport source (
        output valid, rbg_mask_now, prb_word_out, rbg_count, first_rbg_width,
               nominal_rbg_width, bad_request,
        input  ready
    );
    modport sink (
        input  valid, rbg_mask_now, prb_word_out, rbg_count, first_rbg_width,
               nominal_rbg_width, bad_request,
        output ready
    );
endinterface

// Configuration write channel
interface prbg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/prbg_ctrl.sv
`timescale 1ns / 1ps

module prbg_ctrl #(
    parameter int JW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  prbg_pkg::t_dp_sts   i_sts,
    output prbg_pkg::t_dp_cmd   o_cmd,
    output logic [JW-1:0]       o_rbg_idx
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [JW-1:0] r_j, n_j;
    logic          r_out_valid, n_out_valid;
    logic          w_last;
    logic          w_single;

    // Scan ends on the last RBG; interval and read take one step
    assign w_last   = (6'(r_j) + 6'd1) >= 6'(i_sts.nrbg);
    assign w_single = (i_sts.func == prbg_pkg::FUNC_INTERVAL) ||
                      (i_sts.func == prbg_pkg::FUNC_READ);

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_j        = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (w_single || w_last) begin
                    n_state = S_FIN;
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rbg_idx   = r_j;

endmodule

// File: sv/prbg_dp.sv
`timescale 1ns / 1ps

module prbg_dp #(
    parameter int MAX_PRB   = 275,
    parameter int MAX_RBG   = 19,
    parameter int NUM_WORDS = 5,
    parameter int JW        = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    // input item
    input  logic [1:0]          i_func,
    input  logic [8:0]          i_prb_first,
    input  logic [8:0]          i_prb_stop,
    input  logic [2:0]          i_word_index,
    input  logic [63:0]         i_prb_word,
    input  logic [18:0]         i_rbg_mask,
    // control
    input  prbg_pkg::t_dp_cmd   i_cmd,
    input  logic [JW-1:0]       i_rbg_idx,
    output prbg_pkg::t_dp_sts   o_sts,
    // result
    output logic [18:0]         o_rbg_mask_now,
    output logic [63:0]         o_prb_word_out,
    output logic [4:0]          o_rbg_count,
    output logic [4:0]          o_first_rbg_width,
    output logic [4:0]          o_nominal_rbg_width,
    output logic                o_bad_request
);

    localparam int RW = prbg_pkg::RBG_W;

    // Table row limits for the nominal RBG size
    localparam logic [8:0] ROW_SMALL = 9'd36;
    localparam logic [8:0] ROW_MID   = 9'd72;
    localparam logic [8:0] ROW_LARGE = 9'd144;

    // log2 of the nominal RBG size
    function automatic logic [2:0] rbg_shift(input logic [8:0] cnt, input logic c1);
        logic [2:0] s;
        if (cnt <= ROW_SMALL) begin
            s = c1 ? 3'd1 : 3'd2;
        end else if (cnt <= ROW_MID) begin
            s = c1 ? 3'd2 : 3'd3;
        end else if (cnt <= ROW_LARGE) begin
            s = c1 ? 3'd3 : 3'd4;
        end else begin
            s = 3'd4;
        end
        return s;
    endfunction

    // Bits i of a 64-PRB word starting at base with lo <= base+i < hi
    function automatic logic [63:0] range_mask64(input logic [9:0] base,
                                                 input logic [9:0] lo,
                                                 input logic [9:0] hi);
        logic signed [11:0] rel_lo;
        logic signed [11:0] rel_hi;
        logic signed [11:0] pos;
        logic [63:0]        m;
        rel_lo = $signed({2'b00, lo}) - $signed({2'b00, base});
        rel_hi = $signed({2'b00, hi}) - $signed({2'b00, base});
        for (int i = 0; i < 64; i++) begin
            pos  = 12'(i);
            m[i] = (pos >= rel_lo) && (pos < rel_hi);
        end
        return m;
    endfunction

    // Configuration
    logic [8:0] r_cnt;
    logic [8:0] r_start;
    logic       r_cfg1;

    // Latched item
    logic [1:0]  r_func;
    logic [8:0]  r_first;
    logic [8:0]  r_stop;
    logic [2:0]  r_widx;
    logic [63:0] r_word;
    logic [18:0] r_mask;

    // Stores
    logic [RW-1:0] r_rbg, n_rbg;
    logic [63:0]   r_prb [NUM_WORDS];
    logic [63:0]   n_prb [NUM_WORDS];

    // Result register
    logic [18:0] r_o_rbg;
    logic [63:0] r_o_word;
    logic [4:0]  r_o_count;
    logic [4:0]  r_o_first_w;
    logic [4:0]  r_o_p;
    logic        r_o_bad;

    // Derived sizes
    logic [2:0]  c_shift;
    logic [4:0]  c_p;
    logic [3:0]  c_off;
    logic [8:0]  c_n;
    logic [9:0]  c_nrbg_raw;
    logic [4:0]  c_nrbg;
    logic [4:0]  c_first_w;

    assign c_shift    = rbg_shift(r_cnt, r_cfg1);
    assign c_p        = 5'd1 << c_shift;
    assign c_off      = r_start[3:0] & 4'(c_p - 5'd1);
    assign c_n        = (r_cnt > 9'(MAX_PRB)) ? 9'(MAX_PRB) : r_cnt;
    assign c_nrbg_raw = (10'(c_n) + 10'(c_off) + 10'(c_p) - 10'd1) >> c_shift;
    assign c_nrbg     = (c_nrbg_raw > 10'(MAX_RBG)) ? 5'(MAX_RBG) : c_nrbg_raw[4:0];
    assign c_first_w  = c_p - 5'(c_off);

    // Interval: RBG span touched by first..stop-1
    logic       c_bad;
    logic [9:0] c_lo;
    logic [9:0] c_hi;
    logic [9:0] c_hi_clip;
    logic [RW-1:0] c_iv_mask;

    assign c_bad     = (r_stop <= r_first) || (r_stop > c_n);
    assign c_lo      = (10'(r_first) + 10'(c_off)) >> c_shift;
    assign c_hi      = ((10'(r_stop) - 10'd1 + 10'(c_off)) >> c_shift) + 10'd1;
    assign c_hi_clip = (c_hi > 10'(c_nrbg)) ? 10'(c_nrbg) : c_hi;

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            c_iv_mask[k] = (10'(k) >= c_lo) && (10'(k) < c_hi_clip);
        end
    end

    // PRB span of the RBG under scan, clipped to the BWP
    logic [9:0] c_jp;
    logic [9:0] c_rlo;
    logic [9:0] c_rhi_raw;
    logic [9:0] c_rhi;
    logic       c_jvalid;
    logic [RW-1:0] c_sel;
    logic [18:0]   c_mask_sh;
    logic          c_word_hit;
    logic          c_mask_hit;

    assign c_jp      = 10'(i_rbg_idx) << c_shift;
    assign c_rlo     = (i_rbg_idx == '0) ? 10'd0 : (c_jp - 10'(c_off));
    assign c_rhi_raw = c_jp + 10'(c_p) - 10'(c_off);
    assign c_rhi     = (c_rhi_raw > 10'(c_n)) ? 10'(c_n) : c_rhi_raw;
    assign c_jvalid  = 5'(i_rbg_idx) < c_nrbg;
    assign c_mask_sh = r_mask >> i_rbg_idx;
    assign c_mask_hit = c_jvalid && c_mask_sh[0];
    assign c_word_hit = c_jvalid && (r_widx < 3'(NUM_WORDS)) &&
                        (|(r_word & range_mask64(10'(r_widx) << 6, c_rlo, c_rhi)));

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            c_sel[k] = (5'(k) == 5'(i_rbg_idx));
        end
    end

    // RBG store update
    always_comb begin
        n_rbg = r_rbg;
        if (i_cmd.step) begin
            case (r_func)
                prbg_pkg::FUNC_INTERVAL: begin
                    if (!c_bad) begin
                        n_rbg = r_rbg | c_iv_mask;
                    end
                end
                prbg_pkg::FUNC_WORD: begin
                    if (c_word_hit) begin
                        n_rbg = r_rbg | c_sel;
                    end
                end
                default: begin
                    n_rbg = r_rbg;
                end
            endcase
        end
    end

    // PRB store update: every word takes its share of the RBG span
    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            n_prb[w] = r_prb[w];
            if (i_cmd.step && (r_func == prbg_pkg::FUNC_MASK) && c_mask_hit) begin
                n_prb[w] = r_prb[w] | range_mask64(10'(w * 64), c_rlo, c_rhi);
            end
        end
    end

    // Selected PRB word for the result
    logic [63:0] c_rd_word;
    always_comb begin
        c_rd_word = '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
            if (3'(w) == r_widx) begin
                c_rd_word = r_prb[w];
            end
        end
    end

    // Configuration and stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 9'd275;
            r_start <= 9'd0;
            r_cfg1  <= 1'b1;
            r_rbg   <= '0;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_prb[w] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prbg_pkg::CFG_PRB_COUNT:  r_cnt   <= i_cfg_data;
                    prbg_pkg::CFG_PRB_START:  r_start <= i_cfg_data;
                    prbg_pkg::CFG_CONFIG_ONE: r_cfg1  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_rbg <= n_rbg;
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_prb[w] <= n_prb[w];
            end
        end
    end

    // Item and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_first <= i_prb_first;
            r_stop  <= i_prb_stop;
            r_widx  <= i_word_index;
            r_word  <= i_prb_word;
            r_mask  <= i_rbg_mask;
        end
        if (i_cmd.finish) begin
            r_o_rbg     <= 19'(r_rbg);
            r_o_word    <= c_rd_word;
            r_o_count   <= c_nrbg;
            r_o_first_w <= c_first_w;
            r_o_p       <= c_p;
            r_o_bad     <= (r_func == prbg_pkg::FUNC_INTERVAL) && c_bad;
        end
    end

    assign o_sts.func          = r_func;
    assign o_sts.nrbg          = c_nrbg;
    assign o_rbg_mask_now      = r_o_rbg;
    assign o_prb_word_out      = r_o_word;
    assign o_rbg_count         = r_o_count;
    assign o_first_rbg_width   = r_o_first_w;
    assign o_nominal_rbg_width = r_o_p;
    assign o_bad_request       = r_o_bad;

endmodule

// File: sv/prb_rbg_grant_bitmap_core.sv
// Interval and read do not scan the RBGs; PRB word and RBG mask operations scan
// one RBG a cycle over the RBGs of the bandwidth part. A new item is taken only
// when idle, after the result of the last one is loaded; a pending result does
// not block the next input, but the next result waits until it is taken.
// Reset (synchronous, active low) clears both grant stores at once and loads
// the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "prb_rbg_grant_bitmap_core_assert.svh"

module prb_rbg_grant_bitmap_core #(
    parameter int MAX_PRB = 275,
    parameter int MAX_RBG = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prbg_in_if.sink     i_in,
    prbg_out_if.source  o_out,
    prbg_cfg_if.sink    i_cfg
);

    localparam int NUM_WORDS = (MAX_PRB + 63) / 64;
    localparam int JW        = $clog2(MAX_RBG + 1);

    prbg_pkg::t_dp_cmd w_cmd;
    prbg_pkg::t_dp_sts w_sts;
    logic [JW-1:0]     w_rbg_idx;
    logic              w_in_ready;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    // Sequencer
    prbg_ctrl #(
        .JW (JW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rbg_idx   (w_rbg_idx)
    );

    // Stores and mapping arithmetic
    prbg_dp #(
        .MAX_PRB   (MAX_PRB),
        .MAX_RBG   (MAX_RBG),
        .NUM_WORDS (NUM_WORDS),
        .JW        (JW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_func              (i_in.func),
        .i_prb_first         (i_in.prb_first),
        .i_prb_stop          (i_in.prb_stop),
        .i_word_index        (i_in.word_index),
        .i_prb_word          (i_in.prb_word),
        .i_rbg_mask          (i_in.rbg_mask),
        .i_cmd               (w_cmd),
        .i_rbg_idx           (w_rbg_idx),
        .o_sts               (w_sts),
        .o_rbg_mask_now      (o_out.rbg_mask_now),
        .o_prb_word_out      (o_out.prb_word_out),
        .o_rbg_count         (o_out.rbg_count),
        .o_first_rbg_width   (o_out.first_rbg_width),
        .o_nominal_rbg_width (o_out.nominal_rbg_width),
        .o_bad_request       (o_out.bad_request)
    );

    // Checks
    `PRBG_ASSERT(a_busy_after_transfer, i_clk, i_rst_n, (i_in.valid && w_in_ready) |=> !w_in_ready)
    `PRBG_NEVER(a_sizes_consistent, i_clk, i_rst_n, o_out.valid && ((o_out.first_rbg_width > o_out.nominal_rbg_width) || (o_out.rbg_count > 5'(MAX_RBG))))
    `PRBG_NEVER(a_rbg_beyond_count, i_clk, i_rst_n, o_out.valid && ((o_out.rbg_mask_now >> MAX_RBG) != 19'd0))

endmodule
